// ===== sv/hte_pkg.sv =====
// hte_pkg: shared widths, operation codes and rounding/saturation helpers
// for the homogeneous transform engine. No dependencies.
`default_nettype none

package hte_pkg;

    // data format of stored matrix entries and of beat components
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COMP_W     = 32;

    // derived widths
    localparam int OUT_W  = (DATA_WIDTH < COMP_W) ? DATA_WIDTH : COMP_W;
    localparam int PROD_W = DATA_WIDTH + COMP_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SHR_W  = ACC_W - FRAC_BITS;

    // fixed point constants
    localparam logic signed [COMP_W-1:0] FX_ONE_COMP = COMP_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_WIDTH-1:0] MAT_ONE =
        (FRAC_BITS <= DATA_WIDTH - 2) ? (DATA_WIDTH'(1) << FRAC_BITS)
                                      : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    // operation codes
    typedef enum logic [2:0] {
        OP_SET_COL   = 3'd0,
        OP_POINT     = 3'd1,
        OP_ROTATE    = 3'd2,
        OP_VEC4      = 3'd3,
        OP_TRANSLATE = 3'd4,
        OP_SCALE_COL = 3'd5
    } t_op;

    // saturated value with clip flag
    typedef struct packed {
        logic                         clip;
        logic signed [DATA_WIDTH-1:0] val;
    } t_sat_mat;

    typedef struct packed {
        logic                    clip;
        logic signed [OUT_W-1:0] val;
    } t_sat_out;

    // round half up to FRAC_BITS fraction bits
    function automatic logic signed [SHR_W-1:0] fn_round(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] biased;
        biased = acc + RND_HALF;
        return biased[ACC_W-1:FRAC_BITS];
    endfunction

    // clip to the stored entry width
    function automatic t_sat_mat fn_sat_mat(input logic signed [SHR_W-1:0] s);
        t_sat_mat               r;
        logic [SHR_W-DATA_WIDTH:0] top;
        top    = s[SHR_W-1:DATA_WIDTH-1];
        r.clip = !((&top) || !(|top));
        if (r.clip) begin
            r.val = s[SHR_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                               : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end else begin
            r.val = s[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // clip to the result component width
    function automatic t_sat_out fn_sat_out(input logic signed [SHR_W-1:0] s);
        t_sat_out             r;
        logic [SHR_W-OUT_W:0] top;
        top    = s[SHR_W-1:OUT_W-1];
        r.clip = !((&top) || !(|top));
        if (r.clip) begin
            r.val = s[SHR_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                               : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            r.val = s[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/homogeneous_transform_engine_top.sv =====
// homogeneous_transform_engine_top: 4x4 Q16.16 affine transform engine
// with the matrix held in registers. Depends on hte_pkg.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------
//   input    | in        | i_valid / o_stall  | i_operation i_column i_comp_x..w
//   result   | out       | o_valid / i_stall  | o_out_x..o_out_w o_saturated
//
// two register stages: input register, then result register; products, sums,
// rounding, saturation and matrix write-back are combinational between them
// one beat per cycle for every operation while no result held under i_stall blocks a transform beat
// a matrix beat writes the matrix as it leaves, the next beat sees it, no bubble
// synchronous active-low reset empties both registers and loads the identity
// a held result under i_stall keeps a transform beat in place and raises o_stall
`default_nettype none

module homogeneous_transform_engine_top
    import hte_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [2:0]               i_operation,
    input  wire logic [1:0]               i_column,
    input  wire logic signed [COMP_W-1:0] i_comp_x,
    input  wire logic signed [COMP_W-1:0] i_comp_y,
    input  wire logic signed [COMP_W-1:0] i_comp_z,
    input  wire logic signed [COMP_W-1:0] i_comp_w,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [COMP_W-1:0]      o_out_x,
    output logic signed [COMP_W-1:0]      o_out_y,
    output logic signed [COMP_W-1:0]      o_out_z,
    output logic signed [COMP_W-1:0]      o_out_w,
    output logic                          o_saturated
);

    // matrix, indexed [row][column]
    logic signed [DATA_WIDTH-1:0] r_mat [4][4];

    // input stage
    logic                     r_a_valid;
    logic [2:0]               r_a_op;
    logic [1:0]               r_a_col;
    logic signed [COMP_W-1:0] r_a_comp [4];

    // result stage
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_x;
    logic signed [OUT_W-1:0] r_out_y;
    logic signed [OUT_W-1:0] r_out_z;
    logic signed [OUT_W-1:0] r_out_w;
    logic                    r_out_sat;

    // combinational
    logic signed [COMP_W-1:0] a_vec  [4];
    logic signed [PROD_W-1:0] a_prod [4][4];
    logic signed [ACC_W-1:0]  a_sum  [4];
    t_sat_mat                 a_mat_sat [4];
    t_sat_out                 a_out_sat [4];
    t_sat_mat                 a_set_sat [4];
    logic                     a_emits;
    logic                     out_free;
    logic                     a_go;
    logic                     a_free;
    logic                     in_acc;

    // operand vector per operation; scale uses a one-hot column vector
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            a_vec[k] = '0;
        end
        unique case (r_a_op) inside
            OP_POINT, OP_TRANSLATE: begin
                a_vec[0] = r_a_comp[0];
                a_vec[1] = r_a_comp[1];
                a_vec[2] = r_a_comp[2];
                a_vec[3] = FX_ONE_COMP;
            end
            OP_ROTATE: begin
                a_vec[0] = r_a_comp[0];
                a_vec[1] = r_a_comp[1];
                a_vec[2] = r_a_comp[2];
            end
            OP_VEC4: begin
                for (int k = 0; k < 4; k++) begin
                    a_vec[k] = r_a_comp[k];
                end
            end
            OP_SCALE_COL: begin
                a_vec[r_a_col] = r_a_comp[0];
            end
            default: ;
        endcase
    end

    // sixteen entry-by-component products
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
                a_prod[r][k] = r_mat[r][k] * a_vec[k];
            end
        end
    end

    // row sums, rounding and saturation
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            a_sum[r] = ACC_W'(a_prod[r][0]) + ACC_W'(a_prod[r][1])
                     + ACC_W'(a_prod[r][2]) + ACC_W'(a_prod[r][3]);
            a_mat_sat[r] = fn_sat_mat(fn_round(a_sum[r]));
            a_out_sat[r] = fn_sat_out(fn_round(a_sum[r]));
            a_set_sat[r] = fn_sat_mat(SHR_W'(r_a_comp[r]));
        end
    end

    // operation class in the input stage
    always_comb begin
        a_emits = 1'b0;
        unique case (r_a_op) inside
            OP_POINT, OP_ROTATE, OP_VEC4: a_emits = 1'b1;
            default: ;
        endcase
    end

    // stage flow control
    assign out_free = !r_out_valid || !i_stall;
    assign a_go     = r_a_valid && (!a_emits || out_free);
    assign a_free   = !r_a_valid || a_go;
    assign in_acc   = i_valid && a_free;
    assign o_stall  = !a_free;

    // valid bits and matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int r = 0; r < 4; r++) begin
                for (int k = 0; k < 4; k++) begin
                    r_mat[r][k] <= (r == k) ? MAT_ONE : '0;
                end
            end
        end else begin
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_go) begin
                r_a_valid <= 1'b0;
            end
            if (a_go && a_emits) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            // matrix write-back
            if (a_go) begin
                unique case (r_a_op) inside
                    OP_SET_COL: begin
                        for (int r = 0; r < 4; r++) begin
                            r_mat[r][r_a_col] <= a_set_sat[r].val;
                        end
                    end
                    OP_TRANSLATE: begin
                        for (int r = 0; r < 4; r++) begin
                            r_mat[r][3] <= a_mat_sat[r].val;
                        end
                    end
                    OP_SCALE_COL: begin
                        for (int r = 0; r < 4; r++) begin
                            r_mat[r][r_a_col] <= a_mat_sat[r].val;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_op      <= i_operation;
            r_a_col     <= i_column;
            r_a_comp[0] <= i_comp_x;
            r_a_comp[1] <= i_comp_y;
            r_a_comp[2] <= i_comp_z;
            r_a_comp[3] <= i_comp_w;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (a_go && a_emits) begin
            r_out_x <= a_out_sat[0].val;
            r_out_y <= a_out_sat[1].val;
            r_out_z <= a_out_sat[2].val;
            if (r_a_op == OP_VEC4) begin
                r_out_w   <= a_out_sat[3].val;
                r_out_sat <= a_out_sat[0].clip || a_out_sat[1].clip
                          || a_out_sat[2].clip || a_out_sat[3].clip;
            end else begin
                r_out_w   <= '0;
                r_out_sat <= a_out_sat[0].clip || a_out_sat[1].clip
                          || a_out_sat[2].clip;
            end
        end
    end

    // result ports
    assign o_valid     = r_out_valid;
    assign o_out_x     = COMP_W'(r_out_x);
    assign o_out_y     = COMP_W'(r_out_y);
    assign o_out_z     = COMP_W'(r_out_z);
    assign o_out_w     = COMP_W'(r_out_w);
    assign o_saturated = r_out_sat;

    // a result beat appears only from a transform leaving the input stage
    a_out_from_transform: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(a_go && a_emits))
        else $error("result beat without a transform in the input stage");

    // point and rotate results carry a zero w
    a_w_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_go && a_emits && (r_a_op != OP_VEC4)) |=> (o_out_w == '0))
        else $error("non-zero w on a point or rotate result");

    // a stalled result beat holds still
    a_hold_stalled_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_x) && $stable(o_out_w)))
        else $error("stalled result beat changed");

endmodule

`default_nettype wire
